// File: rtl/fr_pkg.sv
// fr_pkg: shared types, codes and constants of the Fresnel reflectance pipeline.
// No dependencies; imported by every module of the block.
package fr_pkg;

  typedef enum logic [1:0] {
    MODE_DIELECTRIC = 2'd0,
    MODE_CONDUCTOR  = 2'd1,
    MODE_NOOP       = 2'd2
  } fr_mode_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_ETA_I = 3'd1,
    REG_ETA_T = 3'd2,
    REG_ETA_C = 3'd3,
    REG_ABS_C = 3'd4
  } fr_reg_e;

  localparam int DIV_BITS   = 30;  // quotient bits of ei^2*sin^2 / et^2
  localparam int ROOT_BITS  = 16;  // result bits of the transmitted cosine root
  localparam int FRAC_BITS  = 15;  // quotient bits of each Q1.15 ratio
  localparam int FR_LATENCY = 5 + DIV_BITS + ROOT_BITS + 2 + FRAC_BITS + 2;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] eta_i;
    logic [15:0] eta_t;
    logic [15:0] eta_c;
    logic [15:0] abs_c;
  } fr_cfg_t;

  // per-item data that rides along with the dielectric root pipeline
  typedef struct packed {
    logic        pos;
    logic        tir;
    logic [16:0] a;
    logic [39:0] s_par;
    logic [39:0] s_perp;
    logic [35:0] ec2;
  } fr_side_t;

endpackage

// File: rtl/fr_front.sv
// fr_front: input register, squares and products, TIR test (five stages).
// Depends on fr_pkg.
module fr_front import fr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fr_cfg_t     cfg_i,
  input  logic        start_i,
  input  logic [15:0] cos_i,
  output logic        valid_o,
  output fr_side_t    side_o,
  output logic [61:0] lhs_o,
  output logic [31:0] et2_o
);

  logic        v0_q, v1_q, v2_q, v3_q, v4_q;
  logic        pos0_q, pos1_q, pos2_q, pos3_q;
  logic [16:0] a0_q, a1_q, a2_q, a3_q;
  logic [16:0] a_d;
  // stage 1
  logic [30:0] asq1_q;
  logic [31:0] ei2_1_q, et2_1_q, n2_1_q, k2_1_q, na1_q;
  logic [33:0] asq_full;
  logic [15:0] ei_s, et_s;
  // stage 2
  logic [30:0] asq2_q, s2_2_q;
  logic [31:0] ei2_2_q, et2_2_q;
  logic [32:0] tf2_q;
  logic [35:0] ec2_2_q;
  // stage 3
  logic [61:0] lhs3_q;
  logic [63:0] tfa3_q;
  logic [39:0] sperp3_q;
  logic [31:0] et2_3_q;
  logic [35:0] ec2_3_q;
  logic [62:0] lhs_full;
  // stage 4
  fr_side_t    side4_q;
  logic [61:0] lhs4_q;
  logic [31:0] et2_4_q;

  assign a_d      = cos_i[15] ? (17'd0 - {cos_i[15], cos_i}) : {1'b0, cos_i};
  assign ei_s     = pos0_q ? cfg_i.eta_i : cfg_i.eta_t;
  assign et_s     = pos0_q ? cfg_i.eta_t : cfg_i.eta_i;
  assign asq_full = 34'(a0_q) * 34'(a0_q);
  assign lhs_full = 63'(ei2_2_q) * 63'(s2_2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos0_q <= ~cos_i[15] & (cos_i != 16'd0);
    a0_q   <= a_d;

    pos1_q  <= pos0_q;
    a1_q    <= a0_q;
    asq1_q  <= asq_full[30:0];
    ei2_1_q <= 32'(ei_s) * 32'(ei_s);
    et2_1_q <= 32'(et_s) * 32'(et_s);
    n2_1_q  <= 32'(cfg_i.eta_c) * 32'(cfg_i.eta_c);
    k2_1_q  <= 32'(cfg_i.abs_c) * 32'(cfg_i.abs_c);
    na1_q   <= 32'(cfg_i.eta_c) * 32'(a0_q);

    pos2_q  <= pos1_q;
    a2_q    <= a1_q;
    asq2_q  <= asq1_q;
    s2_2_q  <= ONE_Q30 - asq1_q;
    ei2_2_q <= ei2_1_q;
    et2_2_q <= et2_1_q;
    tf2_q   <= 33'(n2_1_q) + 33'(k2_1_q);
    ec2_2_q <= {na1_q, 4'b0000};

    pos3_q   <= pos2_q;
    a3_q     <= a2_q;
    lhs3_q   <= lhs_full[61:0];
    tfa3_q   <= 64'(tf2_q) * 64'(asq2_q);
    sperp3_q <= 40'({tf2_q, 6'b000000}) + 40'(asq2_q);
    et2_3_q  <= et2_2_q;
    ec2_3_q  <= ec2_2_q;

    side4_q.pos    <= pos3_q;
    side4_q.tir    <= lhs3_q >= {et2_3_q, 30'd0};
    side4_q.a      <= a3_q;
    side4_q.s_par  <= tfa3_q[63:24] + 40'(ONE_Q30);
    side4_q.s_perp <= sperp3_q;
    side4_q.ec2    <= ec2_3_q;
    lhs4_q         <= lhs3_q;
    et2_4_q        <= et2_3_q;
  end

  assign valid_o = v4_q;
  assign side_o  = side4_q;
  assign lhs_o   = lhs4_q;
  assign et2_o   = et2_4_q;

endmodule

// File: rtl/fr_root.sv
// fr_root: pipelined restoring divider for sin^2 of the transmitted angle,
// then a pipelined bitwise square root giving the transmitted cosine. Depends on fr_pkg.
module fr_root import fr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  fr_side_t    side_i,
  input  logic [61:0] lhs_i,
  input  logic [31:0] et2_i,
  output logic        valid_o,
  output fr_side_t    side_o,
  output logic [15:0] cost_o
);

  logic                dv_q   [DIV_BITS];
  fr_side_t            dside_q[DIV_BITS];
  logic [61:0]         rem_q  [DIV_BITS];
  logic [31:0]         dd_q   [DIV_BITS];
  logic [DIV_BITS-1:0] quo_q  [DIV_BITS];

  logic                sv_q   [ROOT_BITS];
  fr_side_t            sside_q[ROOT_BITS];
  logic [30:0]         srem_q [ROOT_BITS];
  logic [15:0]         res_q  [ROOT_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    logic                v_in;
    fr_side_t            s_in;
    logic [61:0]         r_in, dsh;
    logic [31:0]         d_in;
    logic [DIV_BITS-1:0] q_in;
    logic                ge;
    if (j == 0) begin : g_src
      assign v_in = valid_i;
      assign s_in = side_i;
      assign r_in = lhs_i;
      assign d_in = et2_i;
      assign q_in = '0;
    end else begin : g_src
      assign v_in = dv_q[j-1];
      assign s_in = dside_q[j-1];
      assign r_in = rem_q[j-1];
      assign d_in = dd_q[j-1];
      assign q_in = quo_q[j-1];
    end
    assign dsh = 62'(d_in) << B;
    assign ge  = r_in >= dsh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      dside_q[j] <= s_in;
      dd_q[j]    <= d_in;
      rem_q[j]   <= ge ? (r_in - dsh) : r_in;
      quo_q[j]   <= q_in | (DIV_BITS'(ge) << B);
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int B = ROOT_BITS - 1 - k;
    logic        v_in;
    fr_side_t    s_in;
    logic [30:0] r_in;
    logic [15:0] x_in;
    logic [32:0] trial;
    logic        ge;
    if (k == 0) begin : g_src
      assign v_in = dv_q[DIV_BITS-1];
      assign s_in = dside_q[DIV_BITS-1];
      assign r_in = ONE_Q30 - 31'(quo_q[DIV_BITS-1]);
      assign x_in = '0;
    end else begin : g_src
      assign v_in = sv_q[k-1];
      assign s_in = sside_q[k-1];
      assign r_in = srem_q[k-1];
      assign x_in = res_q[k-1];
    end
    // (x + 2^B)^2 - x^2
    assign trial = (33'(x_in) << (B + 1)) + (33'd1 << (2 * B));
    assign ge    = 33'(r_in) >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else begin
        sv_q[k] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      sside_q[k] <= s_in;
      srem_q[k]  <= ge ? (r_in - trial[30:0]) : r_in;
      res_q[k]   <= x_in | (16'(ge) << B);
    end
  end

  assign valid_o = sv_q[ROOT_BITS-1];
  assign side_o  = sside_q[ROOT_BITS-1];
  assign cost_o  = res_q[ROOT_BITS-1];

endmodule

// File: rtl/fr_back.sv
// fr_back: amplitude terms, two-lane pipelined Q1.15 ratio divider shared by
// both modes, and the final average, saturation and mode select. Depends on fr_pkg.
module fr_back import fr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fr_cfg_t     cfg_i,
  input  logic        valid_i,
  input  fr_side_t    side_i,
  input  logic [15:0] cost_i,
  output logic        done_o,
  output logic [15:0] refl_o,
  output logic        tir_o
);

  // B1: products
  logic        v1_q;
  fr_side_t    s1_q;
  logic [32:0] p1_q, m1_q, p2_q, m2_q;
  logic [15:0] ei_s, et_s;
  // B2: numerator / denominator
  logic        v2_q, tir2_q;
  logic [39:0] num2_q [2];
  logic [40:0] den2_q [2];
  logic        sat2_q [2];
  logic [39:0] num_d  [2];
  logic [40:0] den_d  [2];
  logic [39:0] dnum   [2];
  logic [40:0] dden   [2];
  logic [39:0] cnum   [2];
  logic [40:0] cden   [2];
  // ratio lanes
  logic                 rv_q   [FRAC_BITS];
  logic                 rtir_q [FRAC_BITS];
  logic [40:0]          rrem_q [FRAC_BITS][2];
  logic [40:0]          rden_q [FRAC_BITS][2];
  logic                 rsat_q [FRAC_BITS][2];
  logic [FRAC_BITS-1:0] rquo_q [FRAC_BITS][2];
  // F1 / F2
  logic        v5_q, tir5_q;
  logic [31:0] sq1_q, sq2_q;
  logic [16:0] sum5_q;
  logic [15:0] r1, r2;
  logic [32:0] diel_sum;
  logic [16:0] diel;
  logic [15:0] cond;
  logic        done_q, tir_q;
  logic [15:0] refl_q;
  logic [15:0] refl_d;
  logic        tir_d;

  // index swap follows the item entering B1
  assign ei_s = side_i.pos ? cfg_i.eta_i : cfg_i.eta_t;
  assign et_s = side_i.pos ? cfg_i.eta_t : cfg_i.eta_i;

  always_comb begin
    dnum[0] = (p1_q >= m1_q) ? 40'(p1_q - m1_q) : 40'(m1_q - p1_q);
    dden[0] = 41'(p1_q) + 41'(m1_q);
    dnum[1] = (p2_q >= m2_q) ? 40'(p2_q - m2_q) : 40'(m2_q - p2_q);
    dden[1] = 41'(p2_q) + 41'(m2_q);
    cnum[0] = (s1_q.s_par > 40'(s1_q.ec2)) ? (s1_q.s_par - 40'(s1_q.ec2)) : 40'd0;
    cden[0] = 41'(s1_q.s_par) + 41'(s1_q.ec2);
    cnum[1] = (s1_q.s_perp > 40'(s1_q.ec2)) ? (s1_q.s_perp - 40'(s1_q.ec2)) : 40'd0;
    cden[1] = 41'(s1_q.s_perp) + 41'(s1_q.ec2);
    for (int l = 0; l < 2; l++) begin
      num_d[l] = (cfg_i.mode == MODE_CONDUCTOR) ? cnum[l] : dnum[l];
      den_d[l] = (cfg_i.mode == MODE_CONDUCTOR) ? cden[l] : dden[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= side_i;
    p1_q <= 33'(et_s) * 33'(side_i.a);
    m1_q <= 33'(ei_s) * 33'(cost_i);
    p2_q <= 33'(ei_s) * 33'(side_i.a);
    m2_q <= 33'(et_s) * 33'(cost_i);
    tir2_q <= s1_q.tir;
    for (int l = 0; l < 2; l++) begin
      num2_q[l] <= num_d[l];
      den2_q[l] <= den_d[l];
      sat2_q[l] <= (den_d[l] == 41'd0) || (41'(num_d[l]) == den_d[l]);
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_ratio
    localparam int B = FRAC_BITS - 1 - k;
    logic v_in, t_in;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k] <= 1'b0;
      end else begin
        rv_q[k] <= v_in;
      end
    end
    if (k == 0) begin : g_src
      assign v_in = v2_q;
      assign t_in = tir2_q;
    end else begin : g_src
      assign v_in = rv_q[k-1];
      assign t_in = rtir_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      rtir_q[k] <= t_in;
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [40:0]          r_in, d_in;
      logic                 f_in;
      logic [FRAC_BITS-1:0] q_in;
      logic [41:0]          r2;
      logic                 ge;
      if (k == 0) begin : g_src
        assign r_in = 41'(num2_q[l]);
        assign d_in = den2_q[l];
        assign f_in = sat2_q[l];
        assign q_in = '0;
      end else begin : g_src
        assign r_in = rrem_q[k-1][l];
        assign d_in = rden_q[k-1][l];
        assign f_in = rsat_q[k-1][l];
        assign q_in = rquo_q[k-1][l];
      end
      assign r2 = {r_in, 1'b0};
      assign ge = r2 >= 42'(d_in);
      always_ff @(posedge clk_i) begin
        rrem_q[k][l] <= ge ? 41'(r2 - 42'(d_in)) : r2[40:0];
        rden_q[k][l] <= d_in;
        rsat_q[k][l] <= f_in;
        rquo_q[k][l] <= q_in | (FRAC_BITS'(ge) << B);
      end
    end
  end

  assign r1 = rsat_q[FRAC_BITS-1][0] ? ONE_Q15 : {1'b0, rquo_q[FRAC_BITS-1][0]};
  assign r2 = rsat_q[FRAC_BITS-1][1] ? ONE_Q15 : {1'b0, rquo_q[FRAC_BITS-1][1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v5_q   <= rv_q[FRAC_BITS-1];
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tir5_q <= rtir_q[FRAC_BITS-1];
    sq1_q  <= 32'(r1) * 32'(r1);
    sq2_q  <= 32'(r2) * 32'(r2);
    sum5_q <= 17'(r1) + 17'(r2);
    refl_q <= refl_d;
    tir_q  <= tir_d;
  end

  assign diel_sum = 33'(sq1_q) + 33'(sq2_q);
  assign diel     = diel_sum[32:16];
  assign cond     = sum5_q[16:1];

  always_comb begin
    refl_d = ONE_Q15;
    tir_d  = 1'b0;
    case (cfg_i.mode)
      MODE_DIELECTRIC: begin
        if (tir5_q) begin
          tir_d = 1'b1;
        end else if (diel < 17'(ONE_Q15)) begin
          refl_d = diel[15:0];
        end
      end
      MODE_CONDUCTOR: begin
        if (cond < ONE_Q15) begin
          refl_d = cond;
        end
      end
      default: begin
        refl_d = ONE_Q15;
      end
    endcase
  end

  assign done_o = done_q;
  assign refl_o = refl_q;
  assign tir_o  = tir_q;

endmodule

// File: rtl/fresnel_reflectance.sv
// fresnel_reflectance: top level with configuration registers and checks.
// Depends on fr_pkg, fr_front, fr_root, fr_back.
//
// Fresnel reflectance for one wavelength channel, fully pipelined. One
// signed Q1.15 cosine is taken on every cycle that start is high (busy is
// always low); its result appears on reflectance_o / total_internal_o with
// done_o high for one cycle, in order. The pipeline is built from the
// bit-per-stage units: 5 front stages (squares,
// index products, TIR compare), 30 divider stages for the transmitted sine,
// 16 square-root stages for the transmitted cosine, 2 amplitude stages, 15
// ratio-divider stages and 2 output stages. Results cannot be held off: the
// receiver must take each one in its cycle. Registers (mode, eta_incident,
// eta_transmit, eta_conductor, absorb_conductor at indices 0..4) are written
// through cfg_we_i/cfg_idx_i/cfg_data_i and must only change while no item
// is in flight; writes to other indices are ignored.
module fresnel_reflectance import fr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] cos_incidence_i,
  output logic        done_o,
  output logic [15:0] reflectance_o,
  output logic        total_internal_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  fr_cfg_t     cfg_q;
  logic        fv, rv;
  fr_side_t    fside, rside;
  logic [61:0] lhs;
  logic [31:0] et2;
  logic [15:0] cost;

  // config registers, reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_DIELECTRIC;
      cfg_q.eta_i <= 16'd4096;
      cfg_q.eta_t <= 16'd6144;
      cfg_q.eta_c <= 16'd4096;
      cfg_q.abs_c <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:  cfg_q.mode  <= cfg_data_i[1:0];
        REG_ETA_I: cfg_q.eta_i <= cfg_data_i;
        REG_ETA_T: cfg_q.eta_t <= cfg_data_i;
        REG_ETA_C: cfg_q.eta_c <= cfg_data_i;
        REG_ABS_C: cfg_q.abs_c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the pipeline never stalls
  assign busy = 1'b0;

  fr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (start & ~busy),
    .cos_i   (cos_incidence_i),
    .valid_o (fv),
    .side_o  (fside),
    .lhs_o   (lhs),
    .et2_o   (et2)
  );

  fr_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .side_i  (fside),
    .lhs_i   (lhs),
    .et2_i   (et2),
    .valid_o (rv),
    .side_o  (rside),
    .cost_o  (cost)
  );

  fr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (rv),
    .side_i  (rside),
    .cost_i  (cost),
    .done_o  (done_o),
    .refl_o  (reflectance_o),
    .tir_o   (total_internal_o)
  );

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##FR_LATENCY done_o)
    else $error("item lost in pipeline");

  // no result without an earlier accepted item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, FR_LATENCY))
    else $error("result without item");

  // TIR only in dielectric mode, and then reflectance is exactly one
  a_tir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && total_internal_o) |->
      (reflectance_o == ONE_Q15 && cfg_q.mode == MODE_DIELECTRIC))
    else $error("bad TIR result");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> reflectance_o <= ONE_Q15)
    else $error("reflectance above one");

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for fresnel_reflectance.
// Depends on fr_pkg and the fresnel_reflectance RTL. A scoreboard class
// predicts each reflectance and checks every done_o strobe in order.
`timescale 1ns / 1ps

module testbench;
  import fr_pkg::*;

  // Scoreboard: holds its own copy of the registers, predicts one result per
  // accepted cosine and checks results in arrival order.
  class fresnel_scoreboard;
    bit [1:0]  mode;
    bit [15:0] eta_i, eta_t, eta_c, abs_c;
    bit [16:0] pending[$];   // {total_internal, reflectance}
    int        errors;

    function new();
      mode   = MODE_DIELECTRIC;
      eta_i  = 16'd4096;
      eta_t  = 16'd6144;
      eta_c  = 16'd4096;
      abs_c  = 16'd0;
      errors = 0;
    endfunction

    function void write_reg(fr_reg_e idx, bit [15:0] val);
      case (idx)
        REG_MODE:  mode  = val[1:0];
        REG_ETA_I: eta_i = val;
        REG_ETA_T: eta_t = val;
        REG_ETA_C: eta_c = val;
        REG_ABS_C: abs_c = val;
        default: ;
      endcase
    endfunction

    // bitwise integer square root, truncating
    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Q1.15 ratio limited to one; zero denominator gives one
    function bit [63:0] q15_ratio(bit [63:0] num, bit [63:0] den);
      bit [63:0] q;
      if (den == 0) return 64'd32768;
      q = (num << 15) / den;
      return (q > 64'd32768) ? 64'd32768 : q;
    endfunction

    function bit [63:0] amp_ratio(bit [63:0] p, bit [63:0] m);
      return q15_ratio((p >= m) ? p - m : m - p, p + m);
    endfunction

    function bit [16:0] predict(bit [15:0] cos_raw);
      bit signed [15:0] c;
      bit [63:0] a, ei, et, s2, lhs, cost, r1, r2, refl;
      bit [63:0] tf, a2, ec2, sp, sq, rp, rq;
      bit tir;
      c    = cos_raw;
      a    = (c < 0) ? 64'(-32'(c)) : 64'(c);
      tir  = 0;
      refl = 64'd32768;
      if (mode == MODE_DIELECTRIC) begin
        // indices swap when the cosine is zero or negative
        ei  = (c > 0) ? eta_i : eta_t;
        et  = (c > 0) ? eta_t : eta_i;
        s2  = (64'd1 << 30) - a * a;
        lhs = ei * ei * s2;
        if (lhs >= ((et * et) << 30)) begin
          tir = 1;           // total internal reflection
        end else begin
          cost = int_sqrt((64'd1 << 30) - lhs / (et * et));
          r1   = amp_ratio(et * a, ei * cost);
          r2   = amp_ratio(ei * a, et * cost);
          refl = (r1 * r1 + r2 * r2) >> 16;
        end
      end else if (mode == MODE_CONDUCTOR) begin
        tf   = 64'(eta_c) * eta_c + 64'(abs_c) * abs_c;
        a2   = a * a;
        ec2  = (64'(eta_c) * a) << 4;
        sp   = ((tf * a2) >> 24) + (64'd1 << 30);
        sq   = (tf << 6) + a2;
        rp   = q15_ratio((sp > ec2) ? sp - ec2 : 0, sp + ec2);
        rq   = q15_ratio((sq > ec2) ? sq - ec2 : 0, sq + ec2);
        refl = (rp + rq) >> 1;
      end
      if (refl > 64'd32768) refl = 64'd32768;
      return {tir, refl[15:0]};
    endfunction

    function void note_item(bit [15:0] cos_raw);
      pending = {pending, predict(cos_raw)};
    endfunction

    function void check_result(bit [15:0] refl, bit tir);
      bit [16:0] exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: reflectance %0d total_internal %0d", refl, tir);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r[15:0] !== refl) begin
        $error("reflectance: expected %0d actual %0d", exp_r[15:0], refl);
        errors++;
      end
      if (exp_r[16] !== tir) begin
        $error("total_internal: expected %0d actual %0d", exp_r[16], tir);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] cos_incidence_i = '0;
  logic        done_o;
  logic [15:0] reflectance_o;
  logic        total_internal_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  fresnel_scoreboard sb = new();
  int cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fresnel_reflectance u_top (
    .clk_i, .rst_ni, .start, .busy, .cos_incidence_i,
    .done_o, .reflectance_o, .total_internal_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // results cannot be stalled: take every strobe as it comes
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(reflectance_o, total_internal_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stop sending, then wait until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(fr_reg_e idx, bit [15:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_all(bit [1:0] m, bit [15:0] ei, bit [15:0] et,
                         bit [15:0] ec, bit [15:0] kc);
    write_reg(REG_MODE, 16'(m));
    write_reg(REG_ETA_I, ei);
    write_reg(REG_ETA_T, et);
    write_reg(REG_ETA_C, ec);
    write_reg(REG_ABS_C, kc);
  endtask

  // present one item, hold it until accepted, then, if gap is positive, drop start for the gap
  task automatic send_item(bit [15:0] cos_raw, int gap);
    start           <= 1'b1;
    cos_incidence_i <= cos_raw;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sb.note_item(cos_raw);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic bit [15:0] rand_cos();
    case ($urandom_range(5))
      0: return 16'($urandom_range(7));                   // near zero, positive
      1: return 16'(-$urandom_range(8));                  // near zero, negative
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;  // extremes
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] rand_eta();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'hffff;
      2: return 16'($urandom_range(3072, 12288));  // realistic indices
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  bit [15:0] dir_cos[10] = '{16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h7fff,
                             16'h4000, 16'hc000, 16'h5a82, 16'ha57e, 16'h0100};
  int pct[4] = '{0, 65, 0, 29};

  initial begin
    int gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset indices, both signs (swap and total internal reflection)
    foreach (dir_cos[i]) send_item(dir_cos[i], 0);
    // denser incident side: positive cosines reach total internal reflection
    set_all(MODE_DIELECTRIC, 16'd6144, 16'd4096, 16'd0, 16'hffff);
    for (int i = 0; i < 5; i++) send_item(dir_cos[i], 1);
    // conductor extremes, then the no-op mode, which gives reflectance one
    set_all(MODE_CONDUCTOR, 16'd1, 16'hffff, 16'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_item(dir_cos[i * 2], 0);
    set_all(MODE_CONDUCTOR, 16'hffff, 16'd1, 16'hffff, 16'hffff);
    send_item(16'h7fff, 0);
    send_item(16'h0000, 0);
    set_all(MODE_NOOP, 16'd4096, 16'd6144, 16'd4096, 16'd0);
    send_item(16'h1234, 0);
    send_item(16'h8000, 0);

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 12; ph++) begin
      set_all(2'($urandom_range(2)), rand_eta(), rand_eta(),
              ($urandom_range(7) == 0) ? 16'd0 : rand_eta(),
              ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom));
      for (int i = 0; i < 84; i++) begin
        gap = ($urandom_range(99) < pct[ph % 4]) ? $urandom_range(1, 4) : 0;
        send_item(rand_cos(), gap);
        // one pause until the pipeline is empty
        if (ph == 5 && i == 40) begin
          drain();
        end
      end
    end

    drain();
    repeat (FR_LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
